>>> rtl/sled_pkg.sv
// Shared types and constants for the status LED blink-code sequencer.
// No dependencies; used by the datapath, controller and top level.
package sled_pkg;

  localparam int NUM_SLOTS = 6;

  // Fixed blink timing, in ticks.
  localparam logic [7:0] BLINK_ON_TICKS  = 8'd3;
  localparam logic [7:0] BLINK_GAP_TICKS = 8'd3;
  localparam logic [7:0] BOOT_PERIOD     = 8'd6;
  localparam logic [7:0] BOOT_LIT        = 8'd3;

  // Phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_COLLECT   = 3'd1;
  localparam logic [2:0] PH_BLINK_ON  = 3'd2;
  localparam logic [2:0] PH_BLINK_OFF = 3'd3;
  localparam logic [2:0] PH_TAIL      = 3'd4;

  // Idle display modes.
  localparam logic [1:0] MODE_BOOT  = 2'd0;
  localparam logic [1:0] MODE_HEART = 2'd1;
  localparam logic [1:0] MODE_WAIT  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_BOOT_BLINKS   = 3'd0;
  localparam logic [2:0] REG_HEART_PERIOD  = 3'd1;
  localparam logic [2:0] REG_PULSE_ON      = 3'd2;
  localparam logic [2:0] REG_WAIT_PERIOD   = 3'd3;
  localparam logic [2:0] REG_WAIT_GAP      = 3'd4;
  localparam logic [2:0] REG_COLLECT_TICKS = 3'd5;
  localparam logic [2:0] REG_TAIL_TICKS    = 3'd6;
  localparam logic [2:0] REG_PROBE_ARMED   = 3'd7;

  // Register reset values.
  localparam logic [4:0] RST_BOOT_BLINKS   = 5'd8;
  localparam logic [7:0] RST_HEART_PERIOD  = 8'd50;
  localparam logic [7:0] RST_PULSE_ON      = 8'd4;
  localparam logic [7:0] RST_WAIT_PERIOD   = 8'd100;
  localparam logic [7:0] RST_WAIT_GAP      = 8'd12;
  localparam logic [7:0] RST_COLLECT_TICKS = 8'd15;
  localparam logic [7:0] RST_TAIL_TICKS    = 8'd10;
  localparam logic       RST_PROBE_ARMED   = 1'b1;

  typedef struct packed {
    logic [4:0] boot_blinks;
    logic [7:0] heartbeat_period;
    logic [7:0] pulse_on_ticks;
    logic [7:0] wait_period;
    logic [7:0] wait_gap;
    logic [7:0] collect_ticks;
    logic [7:0] tail_ticks;
    logic       probe_armed;
  } cfg_t;

  typedef struct packed {
    logic                       kscan_press;
    logic                       key_press;
    logic signed [7:0]          key_idx;
    logic                       link_connected;
    logic                       profile_open;
    logic [NUM_SLOTS-1:0][7:0]  report_key;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

>>> rtl/sled_if.sv
// Request channels of the status LED sequencer: tick items in, LED levels out.
// Depends on nothing.
interface sled_in_if;
  logic              valid;
  logic              ready;
  logic              kscan_press;
  logic              key_press;
  logic signed [7:0] key_idx;
  logic              link_connected;
  logic              profile_open;
  logic [7:0]        report_key0;
  logic [7:0]        report_key1;
  logic [7:0]        report_key2;
  logic [7:0]        report_key3;
  logic [7:0]        report_key4;
  logic [7:0]        report_key5;

  modport source (
    output valid, kscan_press, key_press, key_idx, link_connected, profile_open,
    output report_key0, report_key1, report_key2, report_key3, report_key4, report_key5,
    input  ready
  );
  modport sink (
    input  valid, kscan_press, key_press, key_idx, link_connected, profile_open,
    input  report_key0, report_key1, report_key2, report_key3, report_key4, report_key5,
    output ready
  );
endinterface

interface sled_out_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, led_on, input ready);
  modport sink (input valid, led_on, output ready);
endinterface

>>> rtl/sled_dp.sv
// Datapath: event latches, tick counter, phase machine state, serial
// remainder unit and the LED output register. Uses sled_pkg types.
module sled_dp #(
  parameter int REPORT_SLOTS = 6,
  parameter int PIXEL_COUNT  = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  sled_pkg::cfg_t cfg,
  input  sled_pkg::item_t item,
  input  sled_pkg::cmd_t cmd,
  output sled_pkg::sts_t sts,
  output logic           led_on
);

  logic [31:0] tick_count, tick_count_next;
  logic [2:0]  phase, phase_next;
  logic [7:0]  phase_timer, phase_timer_next;
  logic [1:0]  blink_cnt, blink_cnt_next;
  logic        kscan_latch, kscan_latch_next;
  logic        key_latch, key_latch_next;
  logic        report_latch, report_latch_next;

  logic        use_idle, use_idle_next;
  logic        fixed_on, fixed_on_next;
  logic [1:0]  mode, mode_next;
  logic        open_prof;

  logic [31:0] div_num;
  logic [7:0]  div_rem;
  logic [7:0]  div_den, div_den_next;
  logic [4:0]  step_cnt;

  logic        kscan_set, key_set, report_set, key_ok;
  logic [7:0]  tinc;
  logic [7:0]  boot_end;
  logic [8:0]  rem_shift;
  logic [7:0]  rem_step;
  logic        idle_on;
  logic [9:0]  p10, gap10, pulse10, start1, start2;

  // Latch updates for the incoming tick.
  always_comb begin
    key_ok     = !item.key_idx[7] &&
                 ($unsigned(item.key_idx) < 8'(PIXEL_COUNT));
    kscan_set  = item.kscan_press;
    key_set    = cfg.probe_armed && item.key_press && key_ok;
    report_set = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      if (item.report_key[i] != 8'd0) report_set = 1'b1;
    end
  end

  assign boot_end = {1'b0, cfg.boot_blinks, 2'b00} + {2'b00, cfg.boot_blinks, 1'b0} + 8'd2;
  assign tinc     = phase_timer + 8'd1;

  // Phase machine, evaluated on the tick being loaded.
  always_comb begin
    kscan_latch_next  = kscan_latch | kscan_set;
    key_latch_next    = key_latch | key_set;
    report_latch_next = report_latch | report_set;
    tick_count_next   = tick_count + 32'd1;
    phase_next        = phase;
    phase_timer_next  = phase_timer;
    blink_cnt_next    = blink_cnt;
    use_idle_next     = 1'b0;
    fixed_on_next     = 1'b0;

    unique case (phase)
      sled_pkg::PH_IDLE: begin
        if (kscan_latch_next || key_latch_next || report_latch_next) begin
          phase_next       = sled_pkg::PH_COLLECT;
          phase_timer_next = 8'd0;
        end else begin
          use_idle_next = 1'b1;
        end
      end
      sled_pkg::PH_COLLECT: begin
        phase_timer_next = tinc;
        if (tinc >= cfg.collect_ticks) begin
          phase_timer_next  = 8'd0;
          blink_cnt_next    = {1'b0, kscan_latch_next} + {1'b0, report_latch_next};
          kscan_latch_next  = 1'b0;
          key_latch_next    = 1'b0;
          report_latch_next = 1'b0;
          phase_next = (blink_cnt_next != 2'd0) ? sled_pkg::PH_BLINK_ON
                                                : sled_pkg::PH_IDLE;
        end
      end
      sled_pkg::PH_BLINK_ON: begin
        fixed_on_next    = 1'b1;
        phase_timer_next = tinc;
        if (tinc >= sled_pkg::BLINK_ON_TICKS) begin
          phase_timer_next = 8'd0;
          phase_next       = sled_pkg::PH_BLINK_OFF;
        end
      end
      sled_pkg::PH_BLINK_OFF: begin
        phase_timer_next = tinc;
        if (tinc >= sled_pkg::BLINK_GAP_TICKS) begin
          phase_timer_next = 8'd0;
          blink_cnt_next   = blink_cnt - 2'd1;
          phase_next = (blink_cnt_next != 2'd0) ? sled_pkg::PH_BLINK_ON
                                                : sled_pkg::PH_TAIL;
        end
      end
      sled_pkg::PH_TAIL: begin
        phase_timer_next = tinc;
        if (tinc >= cfg.tail_ticks) begin
          phase_timer_next = 8'd0;
          phase_next       = sled_pkg::PH_IDLE;
        end
      end
      default: phase_next = sled_pkg::PH_IDLE;
    endcase
  end

  // Idle display mode and its modulus; zero periods act as one.
  always_comb begin
    if (tick_count_next < {24'd0, boot_end}) begin
      mode_next    = sled_pkg::MODE_BOOT;
      div_den_next = sled_pkg::BOOT_PERIOD;
    end else if (item.link_connected) begin
      mode_next    = sled_pkg::MODE_HEART;
      div_den_next = (cfg.heartbeat_period != 8'd0) ? cfg.heartbeat_period : 8'd1;
    end else begin
      mode_next    = sled_pkg::MODE_WAIT;
      div_den_next = (cfg.wait_period != 8'd0) ? cfg.wait_period : 8'd1;
    end
  end

  // One restoring remainder step per cycle.
  assign rem_shift = {div_rem, div_num[31]};
  assign rem_step  = (rem_shift >= {1'b0, div_den}) ? 8'(rem_shift - {1'b0, div_den})
                                                    : rem_shift[7:0];

  // LED level from the remainder.
  assign p10     = {2'b00, div_rem};
  assign gap10   = {2'b00, cfg.wait_gap};
  assign pulse10 = {2'b00, cfg.pulse_on_ticks};
  assign start1  = gap10;
  assign start2  = {gap10[8:0], 1'b0};

  always_comb begin
    case (mode)
      sled_pkg::MODE_BOOT:  idle_on = div_rem < sled_pkg::BOOT_LIT;
      sled_pkg::MODE_HEART: idle_on = div_rem < cfg.pulse_on_ticks;
      default: begin
        idle_on = (p10 < pulse10) ||
                  ((p10 >= start1) && (p10 < start1 + pulse10)) ||
                  (!open_prof && (p10 >= start2) && (p10 < start2 + pulse10));
      end
    endcase
  end

  assign sts.div_last = (step_cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 32'd0;
      phase        <= sled_pkg::PH_IDLE;
      phase_timer  <= 8'd0;
      blink_cnt    <= 2'd0;
      kscan_latch  <= 1'b0;
      key_latch    <= 1'b0;
      report_latch <= 1'b0;
      step_cnt     <= 5'd0;
      div_den      <= 8'd1;
    end else begin
      if (cmd.load) begin
        tick_count   <= tick_count_next;
        phase        <= phase_next;
        phase_timer  <= phase_timer_next;
        blink_cnt    <= blink_cnt_next;
        kscan_latch  <= kscan_latch_next;
        key_latch    <= key_latch_next;
        report_latch <= report_latch_next;
        step_cnt     <= 5'd0;
        div_den      <= div_den_next;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      use_idle  <= use_idle_next;
      fixed_on  <= fixed_on_next;
      mode      <= mode_next;
      open_prof <= item.profile_open;
      div_num   <= tick_count_next;
      div_rem   <= 8'd0;
    end else if (cmd.step) begin
      div_num <= {div_num[30:0], 1'b0};
      div_rem <= rem_step;
    end
    if (cmd.capture) begin
      led_on <= use_idle ? idle_on : fixed_on;
    end
  end

  a_blink_count: assert property (@(posedge clk) disable iff (rst)
    (phase == sled_pkg::PH_BLINK_ON || phase == sled_pkg::PH_BLINK_OFF)
      |-> blink_cnt != 2'd0)
    else $error("blink phase with no blinks left");

  a_blink_timer: assert property (@(posedge clk) disable iff (rst)
    (phase == sled_pkg::PH_BLINK_ON || phase == sled_pkg::PH_BLINK_OFF)
      |-> phase_timer < sled_pkg::BLINK_ON_TICKS)
    else $error("blink timer overran");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> div_den != 8'd0)
    else $error("remainder unit ran with zero modulus");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> div_rem < div_den)
    else $error("remainder not below modulus");

endmodule

>>> rtl/sled_ctrl.sv
// Controller: request handshakes on both channels and sequencing of the
// remainder unit. Uses sled_pkg command and status types.
module sled_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output sled_pkg::cmd_t cmd,
  input  sled_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.capture    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result shown without finishing a tick");

  a_calc_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && sts.div_last) |=> state == S_DONE)
    else $error("remainder sequence did not finish");

endmodule

>>> rtl/status_led_blink_code_sequencer.sv
// Status LED blink-code sequencer top: APB registers, controller, datapath.
// Depends on sled_pkg, sled_if, sled_ctrl and sled_dp.
//
// Each tick item holds the block until its LED level is registered: the
// accepting edge updates the latches and phase machine, the bit-serial
// remainder unit then reduces the 32-bit tick count by the active period one
// bit at a time, and a capture step registers the LED level and offers it.
// A new tick is taken in the cycle after the result is registered, even if that
// result is still waiting on the output channel; the next result then holds in
// its last cycle until the earlier one is taken, and the input stalls meanwhile.
// Registers must be written only while no tick is in flight (not enforced).
module status_led_blink_code_sequencer #(
  parameter int REPORT_SLOTS = 6,
  parameter int PIXEL_COUNT  = 15
) (
  input  logic        clk,
  input  logic        rst,
  sled_in_if.sink     tick,
  sled_out_if.source  led,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sled_pkg::cfg_t  cfg;
  sled_pkg::item_t item;
  sled_pkg::cmd_t  cmd;
  sled_pkg::sts_t  sts;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_blinks      <= sled_pkg::RST_BOOT_BLINKS;
      cfg.heartbeat_period <= sled_pkg::RST_HEART_PERIOD;
      cfg.pulse_on_ticks   <= sled_pkg::RST_PULSE_ON;
      cfg.wait_period      <= sled_pkg::RST_WAIT_PERIOD;
      cfg.wait_gap         <= sled_pkg::RST_WAIT_GAP;
      cfg.collect_ticks    <= sled_pkg::RST_COLLECT_TICKS;
      cfg.tail_ticks       <= sled_pkg::RST_TAIL_TICKS;
      cfg.probe_armed      <= sled_pkg::RST_PROBE_ARMED;
    end else if (wr_en) begin
      unique case (reg_idx)
        sled_pkg::REG_BOOT_BLINKS:   cfg.boot_blinks      <= pwdata[4:0];
        sled_pkg::REG_HEART_PERIOD:  cfg.heartbeat_period <= pwdata[7:0];
        sled_pkg::REG_PULSE_ON:      cfg.pulse_on_ticks   <= pwdata[7:0];
        sled_pkg::REG_WAIT_PERIOD:   cfg.wait_period      <= pwdata[7:0];
        sled_pkg::REG_WAIT_GAP:      cfg.wait_gap         <= pwdata[7:0];
        sled_pkg::REG_COLLECT_TICKS: cfg.collect_ticks    <= pwdata[7:0];
        sled_pkg::REG_TAIL_TICKS:    cfg.tail_ticks       <= pwdata[7:0];
        sled_pkg::REG_PROBE_ARMED:   cfg.probe_armed      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sled_pkg::REG_BOOT_BLINKS:   prdata = {27'd0, cfg.boot_blinks};
      sled_pkg::REG_HEART_PERIOD:  prdata = {24'd0, cfg.heartbeat_period};
      sled_pkg::REG_PULSE_ON:      prdata = {24'd0, cfg.pulse_on_ticks};
      sled_pkg::REG_WAIT_PERIOD:   prdata = {24'd0, cfg.wait_period};
      sled_pkg::REG_WAIT_GAP:      prdata = {24'd0, cfg.wait_gap};
      sled_pkg::REG_COLLECT_TICKS: prdata = {24'd0, cfg.collect_ticks};
      sled_pkg::REG_TAIL_TICKS:    prdata = {24'd0, cfg.tail_ticks};
      sled_pkg::REG_PROBE_ARMED:   prdata = {31'd0, cfg.probe_armed};
      default:                     prdata = 32'd0;
    endcase
  end

  assign item.kscan_press    = tick.kscan_press;
  assign item.key_press      = tick.key_press;
  assign item.key_idx        = tick.key_idx;
  assign item.link_connected = tick.link_connected;
  assign item.profile_open   = tick.profile_open;
  assign item.report_key[0]  = tick.report_key0;
  assign item.report_key[1]  = tick.report_key1;
  assign item.report_key[2]  = tick.report_key2;
  assign item.report_key[3]  = tick.report_key3;
  assign item.report_key[4]  = tick.report_key4;
  assign item.report_key[5]  = tick.report_key5;

  sled_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (led.valid),
    .out_ready (led.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sled_dp #(
    .REPORT_SLOTS (REPORT_SLOTS),
    .PIXEL_COUNT  (PIXEL_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .led_on (led.led_on)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for status_led_blink_code_sequencer: tick requests in, LED levels out.
// Depends on sled_pkg and the sled_in_if / sled_out_if interfaces from the RTL.
// Expected LED levels come from a local predictor stepped on every accepted tick.
module tb;

  localparam int SLOTS       = 6;
  localparam int PIXELS      = 15;
  localparam int LATENCY     = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sled_in_if  tick ();
  sled_out_if led ();

  status_led_blink_code_sequencer #(
    .REPORT_SLOTS(SLOTS),
    .PIXEL_COUNT (PIXELS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick.sink),
    .led    (led.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state
  sled_pkg::cfg_t m_cfg;
  logic [31:0]    m_ticks;
  logic [2:0]     m_phase;
  logic [7:0]     m_timer;
  logic [1:0]     m_blinks;
  logic           m_kscan;
  logic           m_key;
  logic           m_report;

  sled_pkg::item_t tick_backlog[$];
  logic            led_expected[$];
  sled_pkg::item_t cur_tick;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cnt;
  bit hold_armed;
  int mismatches;
  int cycles;
  bit link_st;
  bit open_st;

  always #6 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // Phase timer step: true when the limit is reached, timer then cleared.
  function automatic bit timer_hit(logic [7:0] lim);
    m_timer = m_timer + 8'd1;
    if (m_timer >= lim) begin
      m_timer = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic idle_lit(logic conn, logic open);
    int unsigned boot_end;
    int unsigned per;
    int unsigned p;
    int unsigned nblips;
    int unsigned start;
    int unsigned i;
    logic lit;
    boot_end = int'(m_cfg.boot_blinks) * int'(sled_pkg::BOOT_PERIOD) + 2;
    if (m_ticks < boot_end) return (m_ticks % sled_pkg::BOOT_PERIOD) < sled_pkg::BOOT_LIT;
    if (conn) begin
      per = (m_cfg.heartbeat_period == 8'd0) ? 1 : m_cfg.heartbeat_period;
      return (m_ticks % per) < m_cfg.pulse_on_ticks;
    end
    per = (m_cfg.wait_period == 8'd0) ? 1 : m_cfg.wait_period;
    p = m_ticks % per;
    nblips = open ? 2 : 3;
    lit = 1'b0;
    for (i = 0; i < nblips; i++) begin
      start = i * m_cfg.wait_gap;
      if (p >= start && p < start + m_cfg.pulse_on_ticks) lit = 1'b1;
    end
    return lit;
  endfunction

  function automatic logic led_model_step(sled_pkg::item_t t);
    logic       lit;
    logic [7:0] idx;
    int         i;
    lit = 1'b0;
    idx = t.key_idx;  // negatives land high and fail the range test
    if (t.kscan_press) m_kscan = 1'b1;
    if (m_cfg.probe_armed && t.key_press && idx < 8'(PIXELS)) m_key = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      if (t.report_key[i] != 8'd0) m_report = 1'b1;
    end
    m_ticks = m_ticks + 32'd1;
    case (m_phase)
      sled_pkg::PH_IDLE: begin
        if (m_kscan || m_key || m_report) begin
          m_phase = sled_pkg::PH_COLLECT;
          m_timer = 8'd0;
        end else begin
          lit = idle_lit(t.link_connected, t.profile_open);
        end
      end
      sled_pkg::PH_COLLECT: begin
        if (timer_hit(m_cfg.collect_ticks)) begin
          m_blinks = {1'b0, m_kscan} + {1'b0, m_report};
          m_kscan  = 1'b0;
          m_key    = 1'b0;
          m_report = 1'b0;
          m_phase  = (m_blinks != 2'd0) ? sled_pkg::PH_BLINK_ON : sled_pkg::PH_IDLE;
        end
      end
      sled_pkg::PH_BLINK_ON: begin
        lit = 1'b1;
        if (timer_hit(sled_pkg::BLINK_ON_TICKS)) m_phase = sled_pkg::PH_BLINK_OFF;
      end
      sled_pkg::PH_BLINK_OFF: begin
        if (timer_hit(sled_pkg::BLINK_GAP_TICKS)) begin
          m_blinks = m_blinks - 2'd1;
          m_phase  = (m_blinks != 2'd0) ? sled_pkg::PH_BLINK_ON : sled_pkg::PH_TAIL;
        end
      end
      sled_pkg::PH_TAIL: begin
        if (timer_hit(m_cfg.tail_ticks)) m_phase = sled_pkg::PH_IDLE;
      end
      default: m_phase = sled_pkg::PH_IDLE;
    endcase
    return lit;
  endfunction

  // Tick request driver
  always @(posedge clk) begin
    if (rst) begin
      tick.valid <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) led_expected.push_back(led_model_step(cur_tick));
      if (!tick.valid || tick.ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_tick = tick_backlog.pop_front();
          tick.valid          <= 1'b1;
          tick.kscan_press    <= cur_tick.kscan_press;
          tick.key_press      <= cur_tick.key_press;
          tick.key_idx        <= cur_tick.key_idx;
          tick.link_connected <= cur_tick.link_connected;
          tick.profile_open   <= cur_tick.profile_open;
          tick.report_key0    <= cur_tick.report_key[0];
          tick.report_key1    <= cur_tick.report_key[1];
          tick.report_key2    <= cur_tick.report_key[2];
          tick.report_key3    <= cur_tick.report_key[3];
          tick.report_key4    <= cur_tick.report_key[4];
          tick.report_key5    <= cur_tick.report_key[5];
        end else begin
          tick.valid <= 1'b0;
        end
      end
    end
  end

  // LED receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      led.ready <= 1'b0;
    end else if (hold_armed && hold_cnt < HOLD_CYCLES) begin
      hold_cnt  <= hold_cnt + 1;
      led.ready <= 1'b0;
    end else begin
      led.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // LED monitor
  always @(posedge clk) begin
    if (!rst && led.valid && led.ready) begin
      if (led_expected.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("cycle %0d: unexpected LED request, led_on=%b", cycles, led.led_on);
      end else if (led.led_on !== led_expected[0]) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("cycle %0d: led_on expected %b got %b",
                   cycles, led_expected[0], led.led_on);
        void'(led_expected.pop_front());
      end else begin
        void'(led_expected.pop_front());
      end
    end
  end

  function automatic sled_pkg::cfg_t make_cfg(int bb, int hp, int po, int wp, int wg, int ct,
                                              int tt, int pa);
    sled_pkg::cfg_t c;
    c.boot_blinks      = 5'(bb);
    c.heartbeat_period = 8'(hp);
    c.pulse_on_ticks   = 8'(po);
    c.wait_period      = 8'(wp);
    c.wait_gap         = 8'(wg);
    c.collect_ticks    = 8'(ct);
    c.tail_ticks       = 8'(tt);
    c.probe_armed      = 1'(pa);
    return c;
  endfunction

  function automatic sled_pkg::cfg_t rand_cfg();
    return make_cfg($urandom_range(0, 31), $urandom_range(1, 255), $urandom_range(1, 255),
                    $urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 40),
                    $urandom_range(1, 40), $urandom_range(0, 1));
  endfunction

  function automatic sled_pkg::item_t dir_tick(bit ks, bit kp, int idx, bit lc, bit po,
                                               int slot, int code);
    sled_pkg::item_t t;
    t = '0;
    t.kscan_press    = ks;
    t.key_press      = kp;
    t.key_idx        = 8'(idx);
    t.link_connected = lc;
    t.profile_open   = po;
    if (slot >= 0) t.report_key[slot] = 8'(code);
    return t;
  endfunction

  // Mostly quiet ticks so blink codes run to the end; link state changes slowly.
  function automatic sled_pkg::item_t gen_tick();
    sled_pkg::item_t t;
    int              r;
    logic [63:0]     rnd;
    if ($urandom_range(0, 49) == 0) link_st = ~link_st;
    if ($urandom_range(0, 49) == 0) open_st = ~open_st;
    t = '0;
    t.link_connected = link_st;
    t.profile_open   = open_st;
    t.key_idx        = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 199);
    if (r < 4) t.kscan_press = 1'b1;
    if (r >= 2 && r < 9) begin
      t.key_press = 1'b1;
      t.key_idx   = $urandom_range(0, 1) ? 8'($urandom_range(0, PIXELS - 1))
                                         : 8'($urandom_range(0, 255));
    end
    if (r >= 7 && r < 12) t.report_key[$urandom_range(0, SLOTS - 1)] = 8'($urandom_range(1, 255));
    if (r >= 196) begin
      rnd = {$urandom(), $urandom()};
      t = rnd[59:0];
    end
    return t;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_cfg(sled_pkg::cfg_t c);
    write_reg(sled_pkg::REG_BOOT_BLINKS,   32'(c.boot_blinks));
    write_reg(sled_pkg::REG_HEART_PERIOD,  32'(c.heartbeat_period));
    write_reg(sled_pkg::REG_PULSE_ON,      32'(c.pulse_on_ticks));
    write_reg(sled_pkg::REG_WAIT_PERIOD,   32'(c.wait_period));
    write_reg(sled_pkg::REG_WAIT_GAP,      32'(c.wait_gap));
    write_reg(sled_pkg::REG_COLLECT_TICKS, 32'(c.collect_ticks));
    write_reg(sled_pkg::REG_TAIL_TICKS,    32'(c.tail_ticks));
    write_reg(sled_pkg::REG_PROBE_ARMED,   32'(c.probe_armed));
    m_cfg = c;
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || tick.valid || led_expected.size() != 0);
  endtask

  task automatic run_phase(int n);
    int k;
    @(negedge clk);
    for (k = 0; k < n; k++) tick_backlog.push_back(gen_tick());
    wait_drain();
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int k;
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    hold_cnt = 0;
    hold_armed = 1'b0;
    link_st = 1'b0;
    open_st = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 45;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick.valid = 1'b0;
    tick.kscan_press = 1'b0;
    tick.key_press = 1'b0;
    tick.key_idx = '0;
    tick.link_connected = 1'b0;
    tick.profile_open = 1'b0;
    tick.report_key0 = '0;
    tick.report_key1 = '0;
    tick.report_key2 = '0;
    tick.report_key3 = '0;
    tick.report_key4 = '0;
    tick.report_key5 = '0;
    led.ready = 1'b0;
    m_cfg = make_cfg(sled_pkg::RST_BOOT_BLINKS, sled_pkg::RST_HEART_PERIOD,
                     sled_pkg::RST_PULSE_ON, sled_pkg::RST_WAIT_PERIOD,
                     sled_pkg::RST_WAIT_GAP, sled_pkg::RST_COLLECT_TICKS,
                     sled_pkg::RST_TAIL_TICKS, sled_pkg::RST_PROBE_ARMED);
    m_ticks = '0;
    m_phase = sled_pkg::PH_IDLE;
    m_timer = '0;
    m_blinks = '0;
    m_kscan = 1'b0;
    m_key = 1'b0;
    m_report = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: boot signature at reset values, out-of-range key indexes,
    // a valid key opening the window, kscan and reports (slots 0 and 5) during collect.
    tick_backlog.push_back(dir_tick(0, 0, 0, 0, 0, -1, 0));
    tick_backlog.push_back(dir_tick(0, 0, 0, 1, 1, -1, 0));
    tick_backlog.push_back(dir_tick(0, 1, -128, 0, 0, -1, 0));
    tick_backlog.push_back(dir_tick(0, 1, PIXELS, 1, 0, -1, 0));
    tick_backlog.push_back(dir_tick(0, 1, 127, 0, 1, -1, 0));
    tick_backlog.push_back(dir_tick(0, 1, -1, 1, 1, -1, 0));
    tick_backlog.push_back(dir_tick(0, 1, PIXELS - 1, 0, 0, -1, 0));
    tick_backlog.push_back(dir_tick(1, 0, 0, 0, 0, 0, 255));
    tick_backlog.push_back(dir_tick(0, 0, 0, 1, 0, 5, 1));
    for (k = 0; k < 13; k++) tick_backlog.push_back(dir_tick(0, 0, 0, k % 2, 0, -1, 0));
    wait_drain();

    // Long boot signature while the tick count is still low
    program_cfg(make_cfg(31, 10, 2, 40, 5, 4, 3, 1));
    run_phase(120);
    program_cfg(make_cfg(sled_pkg::RST_BOOT_BLINKS, sled_pkg::RST_HEART_PERIOD,
                         sled_pkg::RST_PULSE_ON, sled_pkg::RST_WAIT_PERIOD,
                         sled_pkg::RST_WAIT_GAP, sled_pkg::RST_COLLECT_TICKS,
                         sled_pkg::RST_TAIL_TICKS, sled_pkg::RST_PROBE_ARMED));
    run_phase(230);
    program_cfg(make_cfg(0, 1, 1, 1, 1, 1, 1, 0));
    run_phase(230);

    tx_idle_pct = 45;
    rx_idle_pct = 34;
    program_cfg(make_cfg(31, 255, 255, 255, 255, 255, 255, 1));
    run_phase(230);
    // zero periods and window lengths
    program_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0, 1));
    run_phase(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed = 1'b1;
    program_cfg(rand_cfg());
    run_phase(230);
    program_cfg(rand_cfg());
    run_phase(230);

    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && led_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
